>>> hw/rtl/swa_pkg.sv
// Package with the shared widths, codes and stage types of the stream window assigner.
`timescale 1ns / 1ps

package swa_pkg;

    // Limits and field widths.
    localparam int MAX_WINDOWS = 64;
    localparam int KEY_W       = 32;
    localparam int TIME_W      = 47;
    localparam int EDGE_W      = 48;
    localparam int CFG_W       = 32;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
    localparam int PROD_W      = CFG_W + CNT_W;
    localparam int S_DATA_W    = ((KEY_W + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((KEY_W + 2 * EDGE_W + 7) / 8) * 8;

    // Window kinds.
    typedef enum logic [1:0] {
        KIND_TUMBLING = 2'd0,
        KIND_HOPPING  = 2'd1,
        KIND_SLIDING  = 2'd2,
        KIND_SESSION  = 2'd3
    } kind_t;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_KIND    = 8'd0;
    localparam logic [IDX_W-1:0] REG_SIZE    = 8'd1;
    localparam logic [IDX_W-1:0] REG_ADVANCE = 8'd2;
    localparam logic [IDX_W-1:0] REG_GAP     = 8'd3;

    // One stage of the two restoring dividers that run side by side.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] cdv;
        logic [CFG_W-1:0]  rm;
        logic [TIME_W-1:0] q;
        logic [CFG_W-1:0]  rc;
        logic [TIME_W-1:0] qc;
    } div_stage_t;

endpackage

>>> hw/rtl/stream_window_assigner.sv
// Top level of the stream window assigner: divider pipeline, window setup and emitter.
//
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | s_tdata: key_id, event_time
// m_      | out       | m_tvalid/m_tready  | m_tdata: window_key, start_time, end_time;
//         |           |                    | m_tlast: last_window
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A record enters in every cycle while s_tready is high; it passes the 47 stages of the
// pipelined timestamp divider, three setup stages, the emitter and the output register.
// The emitter steps through one hopping candidate per cycle while the output is free,
// and a hopping record has n = min(ceil(size/advance), floor(t/advance) + 1, MAX_WINDOWS)
// candidates; a hopping record without windows drops in stage C, other kinds give one window.
// Reset clears the valid bits and loads the register reset values.
// A stall at the output holds the emitter; the stages behind it stop once a record
// waits at the emitter's input, and nothing is lost or repeated.
`timescale 1ns / 1ps

module stream_window_assigner (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: key_id[31:0], event_time[78:32], zero pad.
    input  logic [swa_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0: window_key[31:0], start_time[79:32], end_time[127:80].
    output logic [swa_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [swa_pkg::IDX_W-1:0]    cfg_index,
    input  logic [swa_pkg::CFG_W-1:0]    cfg_data
);
    import swa_pkg::*;

    localparam int NSTG = TIME_W;

    // Configuration registers.
    kind_t            kind_reg;
    logic [CFG_W-1:0] size_reg, adv_reg, gap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_TUMBLING;
            size_reg <= 32'd60000;
            adv_reg  <= 32'd60000;
            gap_reg  <= 32'd30000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KIND:    kind_reg <= kind_t'(cfg_data[1:0]);
                REG_SIZE:    size_reg <= cfg_data;
                REG_ADVANCE: adv_reg  <= cfg_data;
                REG_GAP:     gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Divisors, with zero acting as one.
    logic [CFG_W-1:0] adv1, size1, dmain;
    assign adv1  = (adv_reg == '0) ? CFG_W'(1) : adv_reg;
    assign size1 = (size_reg == '0) ? CFG_W'(1) : size_reg;
    assign dmain = (kind_reg == KIND_TUMBLING) ? size1 : adv1;

    logic pipe_en;

    // Divider pipeline: stage j settles quotient bit TIME_W-1-j of both divisions.
    div_stage_t pipe_reg  [0:NSTG];
    div_stage_t pipe_next [0:NSTG];
    logic       vld_reg   [0:NSTG];

    function automatic div_stage_t div_step(div_stage_t a, logic tb, logic cb,
                                            logic [CFG_W-1:0] dm, logic [CFG_W-1:0] da);
        div_stage_t   r;
        logic [CFG_W:0] trial, trialc;
        r      = a;
        trial  = {a.rm, tb};
        trialc = {a.rc, cb};
        if (trial >= {1'b0, dm}) begin
            r.rm = CFG_W'(trial - {1'b0, dm});
            r.q  = {a.q[TIME_W-2:0], 1'b1};
        end else begin
            r.rm = trial[CFG_W-1:0];
            r.q  = {a.q[TIME_W-2:0], 1'b0};
        end
        if (trialc >= {1'b0, da}) begin
            r.rc = CFG_W'(trialc - {1'b0, da});
            r.qc = {a.qc[TIME_W-2:0], 1'b1};
        end else begin
            r.rc = trialc[CFG_W-1:0];
            r.qc = {a.qc[TIME_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Input capture: the ceiling dividend is size + advance - 1.
    always_comb begin
        pipe_next[0].key = s_tdata[KEY_W-1:0];
        pipe_next[0].t   = s_tdata[KEY_W+TIME_W-1:KEY_W];
        pipe_next[0].cdv = TIME_W'({1'b0, size_reg} + {1'b0, adv1} - 33'd1);
        pipe_next[0].rm  = '0;
        pipe_next[0].q   = '0;
        pipe_next[0].rc  = '0;
        pipe_next[0].qc  = '0;
        for (int j = 0; j < NSTG; j++) begin
            pipe_next[j+1] = div_step(pipe_reg[j], pipe_reg[j].t[TIME_W-1-j],
                                      pipe_reg[j].cdv[TIME_W-1-j], dmain, adv1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= NSTG; j++) vld_reg[j] <= 1'b0;
        end else if (pipe_en) begin
            vld_reg[0] <= s_tvalid;
            for (int j = 0; j < NSTG; j++) vld_reg[j+1] <= vld_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int j = 0; j <= NSTG; j++) pipe_reg[j] <= pipe_next[j];
        end
    end

    // Stage A: window count, first start, emptiness.
    logic              a_valid_reg, a_empty_reg;
    logic [KEY_W-1:0]  a_key_reg;
    logic [TIME_W-1:0] a_t_reg, a_first_reg;
    logic [CNT_W-1:0]  a_n_reg;
    kind_t             a_kind_reg;

    logic [EDGE_W-1:0] nonneg, nmin;
    logic [CNT_W-1:0]  n_cnt;
    logic              hop_empty;

    always_comb begin
        nonneg = {1'b0, pipe_reg[NSTG].q} + EDGE_W'(1);
        nmin   = ({1'b0, pipe_reg[NSTG].qc} < nonneg) ? {1'b0, pipe_reg[NSTG].qc} : nonneg;
        if (nmin > EDGE_W'(MAX_WINDOWS)) nmin = EDGE_W'(MAX_WINDOWS);
        n_cnt     = nmin[CNT_W-1:0];
        hop_empty = (n_cnt == '0) || (size_reg <= pipe_reg[NSTG].rm);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_key_reg   <= pipe_reg[NSTG].key;
            a_t_reg     <= pipe_reg[NSTG].t;
            a_first_reg <= pipe_reg[NSTG].t - TIME_W'(pipe_reg[NSTG].rm);
            a_n_reg     <= n_cnt;
            a_empty_reg <= hop_empty;
            a_kind_reg  <= kind_reg;
        end
    end

    // Stage B: offset from the first start back to the earliest candidate.
    logic              b_valid_reg, b_empty_reg;
    logic [KEY_W-1:0]  b_key_reg;
    logic [TIME_W-1:0] b_t_reg, b_first_reg;
    logic [CNT_W-1:0]  b_n_reg;
    kind_t             b_kind_reg;
    logic [PROD_W-1:0] b_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_key_reg   <= a_key_reg;
            b_t_reg     <= a_t_reg;
            b_first_reg <= a_first_reg;
            b_n_reg     <= a_n_reg;
            b_empty_reg <= a_empty_reg;
            b_kind_reg  <= a_kind_reg;
            b_prod_reg  <= PROD_W'((a_n_reg - CNT_W'(1)) * adv1);
        end
    end

    // Stage C: start, length and count of the run per kind; empty runs drop here.
    logic              c_valid_reg, c_hop_reg;
    logic [KEY_W-1:0]  c_key_reg;
    logic [TIME_W-1:0] c_t_reg;
    logic [EDGE_W-1:0] c_s_reg;
    logic [CFG_W-1:0]  c_len_reg;
    logic [CNT_W-1:0]  c_cnt_reg;

    logic [EDGE_W-1:0] s0;
    logic [CFG_W-1:0]  len0;
    logic [CNT_W-1:0]  cnt0;
    logic              keep0;

    always_comb begin
        s0    = {1'b0, b_first_reg};
        len0  = size_reg;
        cnt0  = CNT_W'(1);
        keep0 = 1'b1;
        case (b_kind_reg)
            KIND_HOPPING: begin
                s0    = {1'b0, b_first_reg} - EDGE_W'(b_prod_reg);
                cnt0  = b_n_reg;
                keep0 = !b_empty_reg;
            end
            KIND_SLIDING: begin
                s0   = '0;
                len0 = '0;
            end
            KIND_SESSION: begin
                s0   = {1'b0, b_t_reg};
                len0 = gap_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            c_valid_reg <= b_valid_reg && keep0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_key_reg <= b_key_reg;
            c_t_reg   <= b_t_reg;
            c_s_reg   <= s0;
            c_len_reg <= len0;
            c_cnt_reg <= cnt0;
            c_hop_reg <= (b_kind_reg == KIND_HOPPING);
        end
    end

    // Emitter: one candidate per cycle into the output register, while that register is free.
    logic              e_busy_reg, e_busy_next;
    logic              e_hop_reg;
    logic [KEY_W-1:0]  e_key_reg;
    logic [TIME_W-1:0] e_t_reg;
    logic [EDGE_W-1:0] e_s_reg, e_s_next;
    logic [CFG_W-1:0]  e_len_reg;
    logic [CNT_W-1:0]  e_cnt_reg, e_cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_last_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic [EDGE_W-1:0] m_start_reg, m_end_reg;

    logic              out_free, emit_take, keep_win, load_out;
    logic [EDGE_W-1:0] win_end;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_take = !e_busy_reg || (out_free && e_cnt_reg == CNT_W'(1));
    assign pipe_en   = !c_valid_reg || emit_take;
    assign s_tready  = pipe_en;

    always_comb begin
        win_end      = e_s_reg + EDGE_W'(e_len_reg);
        keep_win     = !e_hop_reg || (win_end > {1'b0, e_t_reg});
        load_out     = 1'b0;
        m_valid_next = m_valid_reg;
        e_busy_next  = e_busy_reg;
        e_s_next     = e_s_reg;
        e_cnt_next   = e_cnt_reg;
        if (out_free) m_valid_next = 1'b0;
        if (e_busy_reg && out_free) begin
            load_out     = keep_win;
            m_valid_next = keep_win;
            e_s_next     = e_s_reg + EDGE_W'(adv1);
            e_cnt_next   = e_cnt_reg - CNT_W'(1);
            if (e_cnt_reg == CNT_W'(1)) e_busy_next = 1'b0;
        end
        if (emit_take && c_valid_reg) begin
            e_busy_next = 1'b1;
            e_s_next    = c_s_reg;
            e_cnt_next  = c_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_busy_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            e_busy_reg  <= e_busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_s_reg   <= e_s_next;
        e_cnt_reg <= e_cnt_next;
        if (emit_take && c_valid_reg) begin
            e_key_reg <= c_key_reg;
            e_t_reg   <= c_t_reg;
            e_len_reg <= c_len_reg;
            e_hop_reg <= c_hop_reg;
        end
        if (load_out) begin
            m_key_reg   <= e_key_reg;
            m_start_reg <= e_s_reg;
            m_end_reg   <= win_end;
            m_last_reg  <= (e_cnt_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_DATA_W'({m_end_reg, m_start_reg, m_key_reg});

endmodule

>>> hw/rtl/swa_checker.sv
// Port checker for the stream window assigner and its bind statement.
`timescale 1ns / 1ps

module swa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [swa_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import swa_pkg::*;

    // A stalled result request keeps its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result request changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A window never ends before it starts.
    a_end_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[KEY_W+2*EDGE_W-1:KEY_W+EDGE_W] >= m_tdata[KEY_W+EDGE_W-1:KEY_W])
        else $error("window end below window start");

endmodule

bind stream_window_assigner swa_checker u_swa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/stream_window_assigner_checker.sv
// Checker that predicts and compares the windows of the stream window assigner.
`timescale 1ns / 1ps

module stream_window_assigner_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [swa_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [swa_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tlast,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [swa_pkg::IDX_W-1:0]    cfg_index,
    input  logic [swa_pkg::CFG_W-1:0]    cfg_data,
    output int                           fail_count,
    output int                           pending_windows
);
    import swa_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [EDGE_W-1:0] start;
        logic [EDGE_W-1:0] stop;
        logic              last;
    } window_t;

    window_t           window_queue[$];
    kind_t             cur_kind;
    logic [CFG_W-1:0]  cur_size;
    logic [CFG_W-1:0]  cur_advance;
    logic [CFG_W-1:0]  cur_gap;

    assign pending_windows = window_queue.size();

    // Queue every window that one record falls into.
    task automatic assign_windows(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] t);
        logic [63:0] d;
        logic [63:0] first;
        logic [63:0] n;
        logic [63:0] nonneg;
        logic [63:0] s;
        logic [63:0] e;
        window_t     w;
        w.key = key;
        w.last = 1'b1;
        case (cur_kind)
            KIND_TUMBLING: begin
                d = (cur_size == 0) ? 64'd1 : 64'(cur_size);
                s = (64'(t) / d) * d;
                w.start = s[EDGE_W-1:0];
                w.stop = 48'(s + 64'(cur_size));
                window_queue = {window_queue, w};
            end
            KIND_SLIDING: begin
                w.start = '0;
                w.stop = '0;
                window_queue = {window_queue, w};
            end
            KIND_SESSION: begin
                w.start = 48'(t);
                w.stop = 48'(64'(t) + 64'(cur_gap));
                window_queue = {window_queue, w};
            end
            default: begin
                d = (cur_advance == 0) ? 64'd1 : 64'(cur_advance);
                first = (64'(t) / d) * d;
                n = (64'(cur_size) + d - 1) / d;
                nonneg = first / d + 1;
                if (n > nonneg) n = nonneg;
                if (n > MAX_WINDOWS) n = MAX_WINDOWS;
                if (n != 0 && first + 64'(cur_size) > 64'(t)) begin
                    for (longint i = n; i > 0; i--) begin
                        s = first - 64'(i - 1) * d;
                        e = s + 64'(cur_size);
                        if (e > 64'(t)) begin
                            w.start = s[EDGE_W-1:0];
                            w.stop = e[EDGE_W-1:0];
                            w.last = (i == 1);
                            window_queue = {window_queue, w};
                        end
                    end
                end
            end
        endcase
    endtask

    // Track registers, predict on each request and compare each window.
    always @(posedge aclk) begin
        window_t got;
        window_t exp_w;
        if (!aresetn) begin
            cur_kind <= KIND_TUMBLING;
            cur_size <= 32'd60000;
            cur_advance <= 32'd60000;
            cur_gap <= 32'd30000;
            fail_count <= 0;
            window_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KIND:    cur_kind <= kind_t'(cfg_data[1:0]);
                    REG_SIZE:    cur_size <= cfg_data;
                    REG_ADVANCE: cur_advance <= cfg_data;
                    REG_GAP:     cur_gap <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                assign_windows(s_tdata[KEY_W-1:0], s_tdata[KEY_W+TIME_W-1:KEY_W]);
            if (m_tvalid && m_tready) begin
                got.key = m_tdata[KEY_W-1:0];
                got.start = m_tdata[KEY_W+EDGE_W-1:KEY_W];
                got.stop = m_tdata[KEY_W+2*EDGE_W-1:KEY_W+EDGE_W];
                got.last = m_tlast;
                if (window_queue.size() == 0) begin
                    $error("unexpected window: key %h start %h", got.key, got.start);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = window_queue.pop_front();
                    if (got !== exp_w) begin
                        if (got.key !== exp_w.key)
                            $error("window_key: expected %h, got %h", exp_w.key, got.key);
                        if (got.start !== exp_w.start)
                            $error("start_time: expected %h, got %h",
                                   exp_w.start, got.start);
                        if (got.stop !== exp_w.stop)
                            $error("end_time: expected %h, got %h", exp_w.stop, got.stop);
                        if (got.last !== exp_w.last)
                            $error("last_window: expected %b, got %b", exp_w.last, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/stream_window_assigner_tb.sv
// Testbench top that drives records and registers into the window assigner.
`timescale 1ns / 1ps

module stream_window_assigner_tb;
    import swa_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    int                    fail_count;
    int                    pending_windows;
    int                    send_idle_pct;
    int                    stall_pct;
    longint                cycle_count;

    stream_window_assigner dut (.*);
    stream_window_assigner_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Cycle limit guards against a hung handshake.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls at random at the current rate.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the block to drain before a register write.
    task automatic wait_idle();
        while (pending_windows != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= '0;
        s_tdata[KEY_W-1:0] <= key;
        s_tdata[KEY_W+TIME_W-1:KEY_W] <= t;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        case ($urandom_range(3))
            0: return TIME_W'($urandom_range(5000));
            1: return TIME_W'({$urandom, $urandom});
            2: return {TIME_W{1'b1}} - TIME_W'($urandom_range(100));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    task automatic configure(input kind_t k, input logic [CFG_W-1:0] sz,
                             input logic [CFG_W-1:0] adv, input logic [CFG_W-1:0] gap);
        s_tvalid <= 1'b0;
        wait_idle();
        write_reg(REG_KIND, CFG_W'(k));
        write_reg(REG_SIZE, sz);
        write_reg(REG_ADVANCE, adv);
        write_reg(REG_GAP, gap);
    endtask

    // Random register setting, mostly with hopping counts kept small.
    task automatic random_setting();
        logic [CFG_W-1:0] sz;
        logic [CFG_W-1:0] adv;
        kind_t k;
        k = kind_t'($urandom_range(3));
        adv = ($urandom_range(3) == 0) ? $urandom : CFG_W'($urandom_range(1, 1000));
        sz = adv * CFG_W'($urandom_range(0, 6)) + CFG_W'($urandom_range(0, 3));
        if ($urandom_range(7) == 0) sz = $urandom;
        configure(k, sz, adv, $urandom);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: reset registers, then each kind with extreme values.
        send_record(32'h0, '0);
        send_record(32'hFFFF_FFFF, {TIME_W{1'b1}});
        configure(KIND_TUMBLING, 32'd0, 32'd1, 32'd0);
        send_record(32'h1234_5678, 47'd777);
        configure(KIND_TUMBLING, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_record(32'hA5A5_A5A5, {TIME_W{1'b1}});
        configure(KIND_SLIDING, 32'd5, 32'd5, 32'd5);
        send_record(32'h5A5A_5A5A, 47'h5555_5555_5555);
        configure(KIND_SESSION, 32'd5, 32'd5, 32'hFFFF_FFFF);
        send_record(32'h0000_FFFF, {TIME_W{1'b1}});
        send_record(32'hFFFF_0000, '0);
        // Hopping: several windows, candidates clipped at time zero, advance beyond size, zero size.
        configure(KIND_HOPPING, 32'd10, 32'd3, 32'd0);
        send_record(32'd1, 47'd0);
        send_record(32'd2, 47'd100);
        configure(KIND_HOPPING, 32'd3, 32'd10, 32'd0);
        send_record(32'd3, 47'd5);
        send_record(32'd4, 47'd21);
        configure(KIND_HOPPING, 32'd0, 32'd0, 32'd0);
        send_record(32'd5, 47'd9);
        // More than the window limit, then the largest count at the top of time.
        configure(KIND_HOPPING, 32'd1000, 32'd1, 32'd0);
        send_record(32'd6, 47'd50);
        send_record(32'd7, {TIME_W{1'b1}});
        configure(KIND_HOPPING, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_record(32'd8, {TIME_W{1'b1}});

        // Random phases over the idling patterns.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            random_setting();
            for (int i = 0; i < 10; i++) begin
                send_record($urandom, rand_time());
                if (ph == 5 && i == 4) begin
                    s_tvalid <= 1'b0;
                    while (pending_windows != 0) @(negedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;

        while (pending_windows != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_windows == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
